// ===== rtl/weighted_tile_draw_without_replacement_defines.svh =====
// Assertion macros for the weighted tile draw block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef WEIGHTED_TILE_DRAW_WITHOUT_REPLACEMENT_DEFINES_SVH
`define WEIGHTED_TILE_DRAW_WITHOUT_REPLACEMENT_DEFINES_SVH

`define WTD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wtd check failed");

`define WTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wtd check failed");

`endif

// ===== rtl/wtd_pkg.sv =====
// Shared types, constants and functions of the weighted tile draw block.
// No dependencies.
package wtd_pkg;

  localparam int unsigned NUM_SYMBOLS = 27;
  localparam int unsigned COUNT_BITS  = 5;
  localparam int unsigned RND_BITS    = 31;
  localparam int unsigned SYM_FIELD_BITS = 5;
  localparam int unsigned LEFT_BITS   = 10;
  localparam int unsigned TABLE_LEN   = 27;

  localparam logic [6:0] CODE_SPACE = 7'd32;
  localparam logic [6:0] CODE_BLANK = 7'd42;
  localparam logic [6:0] CODE_A     = 7'd65;

  localparam logic [3:0] BAG_INIT [TABLE_LEN] = '{
    4'd2,
    4'd9, 4'd2, 4'd2, 4'd4, 4'd12, 4'd2, 4'd3, 4'd2, 4'd9, 4'd1, 4'd1, 4'd4, 4'd2,
    4'd6, 4'd8, 4'd2, 4'd1, 4'd6, 4'd4, 4'd6, 4'd4, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1
  };

  typedef struct packed {
    logic                      kind;
    logic [RND_BITS-1:0]       random_value;
    logic [SYM_FIELD_BITS-1:0] returned_symbol;
  } in_t;

  typedef struct packed {
    logic [6:0]           tile_code;
    logic                 pile_empty;
    logic [LEFT_BITS-1:0] tiles_left;
  } out_t;

  function automatic logic [7:0] init_count(input int unsigned idx,
                                            input int unsigned cnt_bits);
    logic [8:0] cmax;
    logic [7:0] v;
    cmax = 9'((1 << cnt_bits) - 1);
    v    = (idx < TABLE_LEN) ? 8'(BAG_INIT[idx]) : 8'd0;
    if (9'(v) > cmax) begin
      v = 8'(cmax);
    end
    return v;
  endfunction

  function automatic int unsigned init_total(input int unsigned num,
                                             input int unsigned cnt_bits);
    int unsigned sum;
    sum = 0;
    for (int unsigned k = 0; k < num; k++) begin
      sum += 32'(init_count(k, cnt_bits));
    end
    return sum;
  endfunction

  function automatic logic [6:0] code_of(input logic [7:0] sym);
    logic [6:0] c;
    if (sym == 8'd0) begin
      c = CODE_BLANK;
    end else begin
      c = 7'(8'(CODE_A) + sym - 8'd1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/wtd_mod.sv =====
// Iterative restoring modulo unit: one dividend bit per cycle.
// Depends on wtd_pkg.
module wtd_mod #(
  parameter int unsigned TOTAL_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wtd_pkg::RND_BITS-1:0]  dividend_i,
  input  logic [TOTAL_BITS-1:0]         divisor_i,
  output logic                          done_o,
  output logic [TOTAL_BITS-1:0]         rem_o
);

  localparam int unsigned CNT_BITS = $clog2(wtd_pkg::RND_BITS);

  logic                         busy_q, done_q;
  logic [CNT_BITS-1:0]          cnt_q;
  logic [wtd_pkg::RND_BITS-1:0] dvd_q;
  logic [TOTAL_BITS-1:0]        div_q, rem_q;
  logic [TOTAL_BITS:0]          trial;

  assign trial = {rem_q, dvd_q[wtd_pkg::RND_BITS-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_BITS'(wtd_pkg::RND_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[wtd_pkg::RND_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_q <= TOTAL_BITS'(trial - {1'b0, div_q});
      end else begin
        rem_q <= TOTAL_BITS'(trial);
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/wtd_store.sv =====
// Count memory with registered read and per-entry valid bits.
// An entry never written reads as its bag reset value. Depends on wtd_pkg.
module wtd_store #(
  parameter int unsigned NUM_SYMBOLS = wtd_pkg::NUM_SYMBOLS,
  parameter int unsigned COUNT_BITS  = wtd_pkg::COUNT_BITS,
  parameter int unsigned SYM_BITS    = $clog2(NUM_SYMBOLS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [SYM_BITS-1:0]   rd_addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o,
  input  logic                  wr_en_i,
  input  logic [SYM_BITS-1:0]   wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_data_i
);

  logic [COUNT_BITS-1:0]  mem_q [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid_q;
  logic                   rd_valid_q;
  logic [COUNT_BITS-1:0]  rd_mem_q, rd_init_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_mem_q   <= mem_q[rd_addr_i];
      rd_valid_q <= valid_q[rd_addr_i];
      rd_init_q  <= COUNT_BITS'(wtd_pkg::init_count(32'(rd_addr_i), COUNT_BITS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_valid_q ? rd_mem_q : rd_init_q;

endmodule

// ===== rtl/weighted_tile_draw_without_replacement.sv =====
// A draw runs the restoring modulo unit on the random value, then walks the count
// memory one count per cycle to the hit symbol and decrements it; a give-back then
// increments the returned count. An empty pile skips the modulo unit and the walk.
// One transaction in flight; the next is taken the cycle after the result is
// registered. Reset restores the bag distribution through per-entry valid bits
// and clears all control state at once; no clearing pass.
module weighted_tile_draw_without_replacement #(
  parameter int unsigned NUM_SYMBOLS = wtd_pkg::NUM_SYMBOLS,
  parameter int unsigned COUNT_BITS  = wtd_pkg::COUNT_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wtd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wtd_pkg::out_t out_data_o
);

  localparam int unsigned SYM_BITS   = $clog2(NUM_SYMBOLS);
  localparam int unsigned PTR_BITS   = $clog2(NUM_SYMBOLS + 1);
  localparam int unsigned TOTAL_BITS = $clog2(NUM_SYMBOLS * ((1 << COUNT_BITS) - 1) + 1);
  localparam logic [TOTAL_BITS-1:0] TOTAL_INIT =
    TOTAL_BITS'(wtd_pkg::init_total(NUM_SYMBOLS, COUNT_BITS));
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MOD   = 7'b0000010,
    ST_WALK  = 7'b0000100,
    ST_DEC   = 7'b0001000,
    ST_GIVE  = 7'b0010000,
    ST_GWAIT = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [TOTAL_BITS-1:0] total_q, total_d, idx_q, idx_d;
  logic [PTR_BITS-1:0] ptr_q, ptr_d;
  logic pend_q, pend_d, kind_q, kind_d, empty_q, empty_d;
  logic out_valid_q, out_valid_d;
  logic [wtd_pkg::SYM_FIELD_BITS-1:0] ret_q, ret_d;
  logic [SYM_BITS-1:0] last_q, last_d, hit_sym_q, hit_sym_d;
  logic [COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;
  logic [6:0] code_q, code_d;
  wtd_pkg::out_t out_q, out_d;

  logic accept, mod_start, mod_done, give_ok, in_give_ok;
  logic [TOTAL_BITS-1:0] rem, cnt_ext;
  logic rd_en, wr_en;
  logic [SYM_BITS-1:0] rd_addr, wr_addr;
  logic [COUNT_BITS-1:0] rd_data, wr_data;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign mod_start  = accept && (total_q != '0);
  assign give_ok    = kind_q && (32'(ret_q) < NUM_SYMBOLS);
  assign in_give_ok = in_data_i.kind && (32'(in_data_i.returned_symbol) < NUM_SYMBOLS);
  assign cnt_ext    = TOTAL_BITS'(rd_data);

  wtd_mod #(
    .TOTAL_BITS(TOTAL_BITS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_data_i.random_value),
    .divisor_i  (total_q),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  wtd_store #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .COUNT_BITS (COUNT_BITS),
    .SYM_BITS   (SYM_BITS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    kind_d      = kind_q;
    ret_d       = ret_q;
    last_d      = last_q;
    hit_sym_d   = hit_sym_q;
    hit_cnt_d   = hit_cnt_q;
    code_d      = code_q;
    empty_d     = empty_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en       = 1'b0;
    rd_addr     = ptr_q[SYM_BITS-1:0];
    wr_en       = 1'b0;
    wr_addr     = hit_sym_q;
    wr_data     = hit_cnt_q - 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d = in_data_i.kind;
          ret_d  = in_data_i.returned_symbol;
          if (total_q == '0) begin
            code_d  = wtd_pkg::CODE_SPACE;
            empty_d = 1'b1;
            state_d = in_give_ok ? ST_GIVE : ST_FIN;
          end else begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          idx_d   = rem;
          ptr_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en  = (32'(ptr_q) < NUM_SYMBOLS);
        pend_d = rd_en;
        if (rd_en) begin
          ptr_d  = ptr_q + 1'b1;
          last_d = ptr_q[SYM_BITS-1:0];
        end
        if (pend_q) begin
          if (idx_q < cnt_ext) begin
            hit_sym_d = last_q;
            hit_cnt_d = rd_data;
            pend_d    = 1'b0;
            state_d   = ST_DEC;
          end else begin
            idx_d = idx_q - cnt_ext;
          end
        end
      end
      ST_DEC: begin
        wr_en   = 1'b1;
        total_d = total_q - 1'b1;
        code_d  = wtd_pkg::code_of(8'(hit_sym_q));
        empty_d = 1'b0;
        state_d = give_ok ? ST_GIVE : ST_FIN;
      end
      ST_GIVE: begin
        rd_en   = 1'b1;
        rd_addr = SYM_BITS'(ret_q);
        state_d = ST_GWAIT;
      end
      ST_GWAIT: begin
        wr_addr = SYM_BITS'(ret_q);
        wr_data = rd_data + 1'b1;
        if (rd_data != COUNT_MAX) begin
          wr_en   = 1'b1;
          total_d = total_q + 1'b1;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.tile_code  = code_q;
          out_d.pile_empty = empty_q;
          out_d.tiles_left = wtd_pkg::LEFT_BITS'(total_q);
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= TOTAL_INIT;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    ptr_q     <= ptr_d;
    kind_q    <= kind_d;
    ret_q     <= ret_d;
    last_q    <= last_d;
    hit_sym_q <= hit_sym_d;
    hit_cnt_q <= hit_cnt_d;
    code_q    <= code_d;
    empty_q   <= empty_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/wtd_checker.sv =====
// Port checker for the weighted tile draw block, bound to the top level.
// Depends on wtd_pkg and the assertion macro header.
`include "weighted_tile_draw_without_replacement_defines.svh"

module wtd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input wtd_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input wtd_pkg::out_t out_data_o
);

  logic unused_in;
  assign unused_in = ^in_data_i;

  `WTD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && (out_data_o == $past(out_data_o)))
  `WTD_ASSERT_IMP(a_empty_space, out_valid_o && out_data_o.pile_empty, out_data_o.tile_code == wtd_pkg::CODE_SPACE)
  `WTD_ASSERT_IMP(a_drawn_code, out_valid_o && !out_data_o.pile_empty, out_data_o.tile_code != wtd_pkg::CODE_SPACE)
  `WTD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind weighted_tile_draw_without_replacement wtd_checker u_wtd_checker (.*);
